>>> rtl/qnc_pkg.sv
// qnc_pkg: shared constants of the quaternion normalize/canonicalize block.
// No dependencies; used by qnc_div and quaternion_normalize_canonical.
package qnc_pkg;

  // quaternion components per request
  localparam int unsigned NUM_COMP = 4;

  // tolerance register: width, reset value, fraction bits of its unit
  localparam int unsigned TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1024;
  localparam int unsigned TOL_FRAC = 30;

endpackage

>>> rtl/qnc_sqrt.sv
// qnc_sqrt: pipelined integer square root, one result bit per stage.
// Standalone; carries an opaque sideband word alongside each request.
module qnc_sqrt #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [2*W-1:0] rad_i,
  input  logic [SW-1:0]  side_i,
  output logic           vld_o,
  output logic [W-1:0]   root_o,
  output logic [SW-1:0]  side_o
);

  logic           vld_q  [W];
  logic [W:0]     rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];
  logic [SW-1:0]  side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           vld_c;
    logic [W:0]     rem_c;
    logic [W-1:0]   root_c;
    logic [2*W-1:0] rad_c;
    logic [SW-1:0]  side_c;
    logic [W+2:0]   cand;
    logic [W+2:0]   trial;
    logic [W+2:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = rad_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign side_c = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cand  = {rem_c, rad_c[2*W-1 -: 2]};
    assign trial = {1'b0, root_c, 2'b01};
    assign ge    = (cand >= trial);
    assign diff  = cand - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[W:0] : cand[W:0];
        root_q[k] <= {root_c[W-2:0], ge};
        rad_q[k]  <= {rad_c[2*W-3:0], 2'b00};
        side_q[k] <= side_c;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign root_o = root_q[W-1];
  assign side_o = side_q[W-1];

endmodule

>>> rtl/qnc_div.sv
// qnc_div: pipelined restoring divider, four lanes sharing one divisor.
// Depends on qnc_pkg. Quotient = (num * 2^W + floor(den/2)) / den.
module qnc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic [W-1:0]                         den_i,
  input  logic [qnc_pkg::NUM_COMP-1:0][W-2:0]  num_i,
  input  logic [SW-1:0]                        side_i,
  output logic                                 vld_o,
  output logic [qnc_pkg::NUM_COMP-1:0][W-1:0]  quo_o,
  output logic [SW-1:0]                        side_o
);

  localparam int unsigned NC = qnc_pkg::NUM_COMP;

  logic                   vld_q  [W];
  logic [W-1:0]           den_q  [W];
  logic [W-1:0]           low_q  [W];
  logic [NC-1:0][W-1:0]   rem_q  [W];
  logic [NC-1:0][W-1:0]   quo_q  [W];
  logic [SW-1:0]          side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic                 vld_c;
    logic [W-1:0]         den_c;
    logic [W-1:0]         low_c;
    logic [NC-1:0][W-1:0] rem_c;
    logic [NC-1:0][W-1:0] quo_c;
    logic [SW-1:0]        side_c;
    logic [NC-1:0][W-1:0] rem_n;
    logic [NC-1:0][W-1:0] quo_n;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign den_c  = den_i;
      // low word of the dividend is the rounding half
      assign low_c  = {1'b0, den_i[W-1:1]};
      assign quo_c  = '0;
      assign side_c = side_i;
      for (genvar l = 0; l < NC; l++) begin : g_init
        assign rem_c[l] = {1'b0, num_i[l]};
      end
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign den_c  = den_q[k-1];
      assign low_c  = low_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign quo_c  = quo_q[k-1];
      assign side_c = side_q[k-1];
    end

    for (genvar l = 0; l < NC; l++) begin : g_lane
      logic [W:0] cand;
      logic [W:0] diff;
      logic       ge;
      assign cand     = {rem_c[l], low_c[W-1]};
      assign ge       = (cand >= {1'b0, den_c});
      assign diff     = cand - {1'b0, den_c};
      assign rem_n[l] = ge ? diff[W-1:0] : cand[W-1:0];
      assign quo_n[l] = {quo_c[l][W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_c;
        low_q[k]  <= {low_c[W-2:0], 1'b0};
        rem_q[k]  <= rem_n;
        quo_q[k]  <= quo_n;
        side_q[k] <= side_c;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign quo_o  = quo_q[W-1];
  assign side_o = side_q[W-1];

endmodule

>>> rtl/quaternion_normalize_canonical.sv
// Quaternion normalize + sign canonicalization, signed Q3.(W-3) in, Q1.(W-2) out.
// Built around the bit-per-stage square root and divider pipelines; throughput
// one request per cycle unless the skid slot is full and stalls the pipe.
// A two-entry output stage (register + skid) decouples s_axis from m_axis.
// rst_ni async active low: clears all valid bits and loads tolerance 1024.
// Depends on qnc_pkg, qnc_sqrt, qnc_div.
module quaternion_normalize_canonical #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request in; tdata: in_w, in_x, in_y, in_z (each W bits, low to high), zero pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // result out; tdata: out_w, out_x, out_y, out_z (low to high), zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // tuser: status (0 ok, 1 invalid orientation)
  output logic                   m_axis_tuser,
  // tolerance register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [qnc_pkg::TOL_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned W    = COMPONENT_WIDTH;
  localparam int unsigned NC   = qnc_pkg::NUM_COMP;
  localparam int unsigned DW   = ((4*W+7)/8)*8;
  localparam int unsigned FI   = W - 3;           // input fraction bits
  localparam int unsigned FO   = W - 2;           // output fraction bits
  localparam int unsigned CW   = 2*W + 32;        // tolerance compare width
  localparam int unsigned SHL  = (2*FO >= qnc_pkg::TOL_FRAC) ? 2*FO - qnc_pkg::TOL_FRAC : 0;
  localparam int unsigned SHD  = (2*FO >= qnc_pkg::TOL_FRAC) ? 0 : qnc_pkg::TOL_FRAC - 2*FO;

  // 2.0 in Q3.FI, also 1.0 in Q1.FO
  localparam logic [W-1:0]   TWO_IN  = {2'b01, {(W-2){1'b0}}};
  localparam logic [2*W-1:0] NORM_LO = (2*W)'(1) << (2*FI - 1);
  localparam logic [2*W-1:0] NORM_HI = (2*W)'(1) << (2*FI + 1);
  localparam logic [2*W-1:0] ONE_SQ  = (2*W)'(1) << (2*FO);

  typedef struct packed {
    logic                   ok;
    logic [NC-1:0]          neg;
    logic [NC-1:0][W-2:0]   mag;
  } sq_side_t;

  typedef struct packed {
    logic          ok;
    logic [NC-1:0] neg;
  } dv_side_t;

  // ---------------------------------------------------------------
  // tolerance register, always writable
  // ---------------------------------------------------------------
  logic [qnc_pkg::TOL_WIDTH-1:0] tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qnc_pkg::TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------
  // pipeline enable: whole pipe advances unless the skid slot is full
  // ---------------------------------------------------------------
  logic en;
  logic skid_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------
  // stage 1: magnitudes, signs, per-component range check
  // ---------------------------------------------------------------
  logic                 v1_q;
  logic [NC-1:0][W-2:0] mag1_q;
  logic [NC-1:0]        neg1_q;
  logic                 ok1_q;

  logic [NC-1:0][W-2:0] mag_c;
  logic [NC-1:0]        neg_c;
  logic                 ok_c;

  always_comb begin
    logic [W-1:0] comp;
    logic [W-1:0] magf;
    ok_c = 1'b1;
    for (int i = 0; i < NC; i++) begin
      comp     = s_axis_tdata[i*W +: W];
      neg_c[i] = comp[W-1];
      magf     = comp[W-1] ? (~comp + 1'b1) : comp;
      mag_c[i] = magf[W-2:0];
      if (magf > TWO_IN) begin
        ok_c = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 2: squares
  // ---------------------------------------------------------------
  logic                   v2_q;
  logic [NC-1:0][2*W-3:0] sq2_q;
  logic [NC-1:0][W-2:0]   mag2_q;
  logic [NC-1:0]          neg2_q;
  logic                   ok2_q;

  // ---------------------------------------------------------------
  // stage 3: squared norm, norm range check, radicand 16*S
  // ---------------------------------------------------------------
  logic                 v3_q;
  logic [2*W-1:0]       rad3_q;
  sq_side_t             side3_q;

  logic [2*W-1:0] sum_c;
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NC; i++) begin
      sum_c = sum_c + (2*W)'(sq2_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag_c;
      neg1_q <= neg_c;
      ok1_q  <= ok_c;
      for (int i = 0; i < NC; i++) begin
        sq2_q[i] <= (2*W-2)'(mag1_q[i]) * (2*W-2)'(mag1_q[i]);
      end
      mag2_q      <= mag1_q;
      neg2_q      <= neg1_q;
      ok2_q       <= ok1_q;
      rad3_q      <= {sum_c[2*W-5:0], 4'b0000};
      side3_q.ok  <= ok2_q && (sum_c >= NORM_LO) && (sum_c <= NORM_HI);
      side3_q.neg <= neg2_q;
      side3_q.mag <= mag2_q;
    end
  end

  // ---------------------------------------------------------------
  // square root: n = floor(sqrt(16*S)), W stages
  // ---------------------------------------------------------------
  logic           vs;
  logic [W-1:0]   norm_s;
  logic [$bits(sq_side_t)-1:0] side_s_raw;
  sq_side_t       side_s;

  qnc_sqrt #(
    .W  (W),
    .SW ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .rad_i  (rad3_q),
    .side_i (side3_q),
    .vld_o  (vs),
    .root_o (norm_s),
    .side_o (side_s_raw)
  );

  assign side_s = sq_side_t'(side_s_raw);

  // ---------------------------------------------------------------
  // divide each magnitude by the norm, rounded to nearest, W stages
  // ---------------------------------------------------------------
  dv_side_t             dside_in;
  logic                 vd;
  logic [NC-1:0][W-1:0] quo_d;
  logic [$bits(dv_side_t)-1:0] dside_raw;
  dv_side_t             dside;

  assign dside_in.ok  = side_s.ok;
  assign dside_in.neg = side_s.neg;

  qnc_div #(
    .W  (W),
    .SW ($bits(dv_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vs),
    .den_i  (norm_s),
    .num_i  (side_s.mag),
    .side_i (dside_in),
    .vld_o  (vd),
    .quo_o  (quo_d),
    .side_o (dside_raw)
  );

  assign dside = dv_side_t'(dside_raw);

  // ---------------------------------------------------------------
  // stage A: saturate to 1.0; stage B: squares; stage C: squared sum
  // ---------------------------------------------------------------
  logic                   va_q, vb_q, vc_q;
  logic [NC-1:0][W-2:0]   resa_q, resb_q, resc_q;
  logic [NC-1:0]          nega_q, negb_q, negc_q;
  logic                   oka_q, okb_q, okc_q;
  logic [NC-1:0][2*W-3:0] sqb_q;
  logic [2*W-1:0]         tsum_q;

  logic [2*W-1:0] tsum_c;
  always_comb begin
    tsum_c = '0;
    for (int i = 0; i < NC; i++) begin
      tsum_c = tsum_c + (2*W)'(sqb_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= vd;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        resa_q[i] <= (quo_d[i] > TWO_IN) ? TWO_IN[W-2:0] : quo_d[i][W-2:0];
        sqb_q[i]  <= (2*W-2)'(resa_q[i]) * (2*W-2)'(resa_q[i]);
      end
      nega_q <= dside.neg;
      oka_q  <= dside.ok;
      resb_q <= resa_q;
      negb_q <= nega_q;
      okb_q  <= oka_q;
      resc_q <= resb_q;
      negc_q <= negb_q;
      okc_q  <= okb_q;
      tsum_q <= tsum_c;
    end
  end

  // ---------------------------------------------------------------
  // stage D (into output register): tolerance check, sign canonical form
  // ---------------------------------------------------------------
  logic [4*W-1:0] fin_comp;
  logic           fin_bad;

  always_comb begin
    logic [2*W-1:0] dev;
    logic [CW-1:0]  devx;
    logic [CW-1:0]  limx;
    logic           flip;
    logic           found;
    logic           s;
    logic [W-1:0]   rz;
    dev   = (tsum_q >= ONE_SQ) ? (tsum_q - ONE_SQ) : (ONE_SQ - tsum_q);
    devx  = CW'(dev) << SHD;
    limx  = CW'(tol_q) << SHL;
    flip  = 1'b0;
    found = 1'b0;
    // first nonzero result component decides the overall sign
    for (int i = 0; i < NC; i++) begin
      if (!found && (resc_q[i] != '0)) begin
        flip  = negc_q[i];
        found = 1'b1;
      end
    end
    fin_bad = !okc_q || (devx > limx);
    for (int i = 0; i < NC; i++) begin
      rz = {1'b0, resc_q[i]};
      s  = (negc_q[i] != flip) && (resc_q[i] != '0);
      fin_comp[i*W +: W] = fin_bad ? '0 : (s ? (~rz + 1'b1) : rz);
    end
  end

  // ---------------------------------------------------------------
  // output register + skid slot
  // ---------------------------------------------------------------
  logic           out_vld_q;
  logic [4*W:0]   out_data_q;
  logic [4*W:0]   skid_data_q;
  logic           take;

  assign take = en && vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q  <= skid_vld_q || take;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_data_q <= skid_vld_q ? skid_data_q : {fin_bad, fin_comp};
    end else if (take) begin
      skid_data_q <= {fin_bad, fin_comp};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DW'(out_data_q[4*W-1:0]);
  assign m_axis_tuser  = out_data_q[4*W];

`ifndef SYNTH
  // skid slot only holds a request behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot full with empty output register");

  // skid fills only when the output was stalled
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid slot filled without a stall");

  // invalid status always carries zero components
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero components");
`endif

endmodule

>>> test/testbench.sv
// testbench: self-checking bench for quaternion_normalize_canonical.
// Drives random and directed quaternions, predicts each result with an exact
// fixed-point model, and checks it. Depends on qnc_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W = 32;
  localparam int unsigned DW = 4 * W;
  localparam int unsigned LATENCY = 2 * W + 7;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TWO_MAX = 32'h4000_0001;

  typedef struct packed {
    logic [W-1:0] z;
    logic [W-1:0] y;
    logic [W-1:0] x;
    logic [W-1:0] w;
  } quat_t;

  typedef struct {
    quat_t q;
    logic  status;
  } norm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [qnc_pkg::TOL_WIDTH-1:0] cfg_data_i = '0;

  quaternion_normalize_canonical #(.COMPONENT_WIDTH(W)) DUT (.*);

  always #6 clk_i = ~clk_i;

  // model state
  logic [qnc_pkg::TOL_WIDTH-1:0] tolerance;
  norm_result_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned requests_sent = 0;
  longint unsigned cycles = 0;
  bit rx_stall_on = 1'b1;
  bit tx_gap_on = 1'b1;
  int unsigned tx_burst_left = 0;

  // exact predictor; magnitudes up to 2^31, sums well inside 256 bits
  function automatic norm_result_t normalize_quat(quat_t q);
    norm_result_t r;
    logic [W-1:0] comp[4];
    logic [W-1:0] mag[4];
    logic [W-1:0] res[4];
    bit neg[4];
    logic [255:0] sum, tsum, n, num, quo, dev, one, lim;
    bit ok, flip, done;
    comp[0] = q.w; comp[1] = q.x; comp[2] = q.y; comp[3] = q.z;
    ok = 1'b1; sum = '0; tsum = '0; flip = 1'b0; done = 1'b0;
    r.q = '0;
    r.status = 1'b1;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i][W-1];
      mag[i] = neg[i] ? -comp[i] : comp[i];
      if (mag[i] > (64'd1 << (W - 2))) ok = 1'b0;
      sum += 256'(mag[i]) * 256'(mag[i]);
    end
    if (ok && (sum < (256'd1 << (2 * (W - 3) - 1)) || sum > (256'd1 << (2 * (W - 3) + 1))))
      ok = 1'b0;
    if (!ok) return r;
    // integer square root of 16*S, bit by bit
    n = '0;
    for (int b = 63; b >= 0; b--)
      if ((n | (256'd1 << b)) * (n | (256'd1 << b)) <= (sum << 4)) n |= 256'd1 << b;
    for (int i = 0; i < 4; i++) begin
      num = (256'(mag[i]) << W) + (n >> 1);
      quo = num / n;
      if (quo > (256'd1 << (W - 2))) quo = 256'd1 << (W - 2);
      res[i] = quo[W-1:0];
      tsum += 256'(res[i]) * 256'(res[i]);
    end
    for (int i = 0; i < 4; i++)
      if (!done && res[i] != 0) begin
        flip = neg[i];
        done = 1'b1;
      end
    one = 256'd1 << (2 * (W - 2));
    dev = (tsum >= one) ? tsum - one : one - tsum;
    lim = 256'(tolerance) << (2 * (W - 2) - qnc_pkg::TOL_FRAC);
    if (dev > lim) return r;
    for (int i = 0; i < 4; i++)
      if ((neg[i] != flip) && res[i] != 0) res[i] = -res[i];
    r.q = {res[3], res[2], res[1], res[0]};
    r.status = 1'b0;
    return r;
  endfunction

  // sender with bursts and gaps; drives at falling edges, valid stays up
  // between requests of a burst
  task automatic send_quat(quat_t q);
    int unsigned gap;
    if (tx_gap_on && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (tx_burst_left > 0) tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= q;
    expected_q.push_back(normalize_quat(q));
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [qnc_pkg::TOL_WIDTH-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tolerance = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random component in Q3.29, magnitude at most span in units of 2^-29
  function automatic logic [W-1:0] rand_comp(int unsigned span);
    logic [W-1:0] v;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // unit-ish quaternion: w dominant, scale 1.0 or 2.0; norm squared may fall outside [0.5, 2]
  function automatic quat_t rand_unitish();
    quat_t q;
    int unsigned scale;
    scale = $urandom_range(1, 3) == 1 ? 32'h2000_0000 : 32'h4000_0000;
    q.w = rand_comp(scale / 2 + $urandom_range(0, scale / 2));
    q.x = rand_comp($urandom_range(0, scale / 2));
    q.y = rand_comp($urandom_range(0, scale / 3));
    q.z = rand_comp($urandom_range(0, scale / 4));
    if ($urandom_range(0, 4) == 0) q.w = '0;
    if ($urandom_range(0, 6) == 0) q.x = rand_comp(3);
    return q;
  endfunction

  task automatic test_directed();
    quat_t q;
    localparam logic [W-1:0] ONE = 32'h2000_0000;
    localparam logic [W-1:0] TWO = 32'h4000_0000;
    send_quat({32'd0, 32'd0, 32'd0, ONE});
    send_quat({32'd0, 32'd0, 32'd0, -ONE});
    send_quat({32'd0, 32'd0, 32'd0, TWO});           // magnitude exactly two
    send_quat({32'd0, 32'd0, 32'd0, -TWO});
    send_quat({32'd0, 32'd0, 32'd0, TWO + 1});       // just above two
    send_quat({32'd0, 32'd0, 32'd0, 32'h8000_0000}); // most negative
    send_quat({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_quat({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_quat('0);                                    // zero norm
    send_quat({32'd0, 32'd0, 32'h1000_0000, 32'h1000_0000}); // norm^2 exactly 0.5
    send_quat({32'd0, 32'd0, 32'h1000_0000, 32'h0FFF_FFFF}); // just below 0.5
    send_quat({32'd0, 32'd0, ONE, ONE});             // norm^2 exactly 2
    send_quat({32'd0, 32'd0, ONE, ONE + 1});         // just above 2
    send_quat({32'd0, ONE, -ONE, 32'd0});            // leading zero, sign from x
    send_quat({-ONE, 32'd0, 32'd0, 32'd0});          // sign from z
    send_quat({32'd0, 32'd0, ONE, 32'hFFFF_FFFF});   // tiny negative w stays nonzero and decides the sign
    send_quat({-ONE, ONE, 32'h0000_0001, -ONE});
    send_quat({32'h1234_5678, -32'h0765_4321, 32'h0ABC_DEF0, 32'h1111_1111});
    q.w = 32'h5555_5555; q.x = 32'hAAAA_AAAA; q.y = 32'h0F0F_0F0F; q.z = 32'hF0F0_F0F0;
    send_quat(q);
  endtask

  task automatic test_random(int unsigned count);
    quat_t q;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: q = {$urandom, $urandom, $urandom, $urandom};
        1: q = {rand_comp(TWO_MAX), rand_comp(TWO_MAX), rand_comp(TWO_MAX), rand_comp(TWO_MAX)};
        default: q = rand_unitish();
      endcase
      send_quat(q);
    end
  endtask

  task automatic test_tolerance_sweep();
    write_tolerance('0);
    test_random(250);
    write_tolerance(31'h7FFF_FFFF);
    test_random(200);
    write_tolerance(31'h4000_0000);
    test_random(200);
    write_tolerance(31'd3);
    test_random(250);
  endtask

  task automatic test_pause_and_flat_out();
    wait_drained();          // sender holds off until all results are back
    tx_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random(300);
    rx_stall_on = 1'b1;
    test_random(150);
    tx_gap_on = 1'b1;
  endtask

  // receiver stall pattern; sample at rising edge, drive at falling edge
  always @(negedge clk_i)
    if (rst_ni) m_axis_tready <= rx_stall_on ? (($urandom_range(0, 7) < 5) ^ cycles[5]) : 1'b1;

  always @(posedge clk_i) begin
    norm_result_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) invalid_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h status %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata !== DW'(exp_r.q) || m_axis_tuser !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch result %0d: exp %h/%b got %h/%b", results_seen,
                     exp_r.q, exp_r.status, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    tolerance = qnc_pkg::TOL_RESET;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500);
    test_tolerance_sweep();
    write_tolerance(qnc_pkg::TOL_RESET);
    test_pause_and_flat_out();
    wait_drained();
    if (expected_q.size() != 0) mismatches++;
    $display("covered %0d requests, %0d results (%0d invalid), tolerance sweep 0..max",
             requests_sent, results_seen, invalid_seen);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/qnc_pkg.sv
rtl/qnc_sqrt.sv
rtl/qnc_div.sv
rtl/quaternion_normalize_canonical.sv
test/testbench.sv
